### src/werq_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the request queue.
`default_nettype none

package werq_pkg;

  // Defaults for the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  // Fixed field widths of the channels.
  localparam int KIND_W   = 2;
  localparam int TAG_W    = 16;
  localparam int OFFSET_W = 64;
  localparam int COUNT_W  = 5;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W    = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ELEVATOR = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the accepted request
    logic exec;      // decode: push, flush, result defaults, scan setup
    logic scan;      // step the window scan
    logic select;    // settle the chosen entry, head and direction
    logic fetch;     // read the chosen entry
    logic capture;   // take the chosen entry into the result
    logic shift;     // step the compaction behind the chosen entry
    logic pop_end;   // drop one from the fill count
    logic load_out;  // move the result into the output register
  } werq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_go;
    logic elevator;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } werq_sts_t;

endpackage

`default_nettype wire

### src/werq_in_if.sv
// Request channel: valid/ready handshake with the request fields.
`default_nettype none

interface werq_in_if;
  import werq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TAG_W-1:0]    request_tag;
  logic                position_known;
  logic [OFFSET_W-1:0] disk_offset;

  modport source (output valid, kind, request_tag, position_known, disk_offset,
                  input ready);
  modport sink   (input valid, kind, request_tag, position_known, disk_offset,
                  output ready);
endinterface

`default_nettype wire

### src/werq_out_if.sv
// Result channel: valid/ready handshake with the result fields.
`default_nettype none

interface werq_out_if;
  import werq_pkg::*;

  logic                valid;
  logic                ready;
  logic                done_ok;
  logic [TAG_W-1:0]    out_tag;
  logic                out_position_known;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  fill_level;
  logic                heading_up;
  logic [COUNT_W-1:0]  dropped_count;

  modport source (output valid, done_ok, out_tag, out_position_known, out_offset,
                         fill_level, heading_up, dropped_count,
                  input ready);
  modport sink   (input valid, done_ok, out_tag, out_position_known, out_offset,
                        fill_level, heading_up, dropped_count,
                  output ready);
endinterface

`default_nettype wire

### src/werq_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
`default_nettype none

interface werq_cfg_if;
  import werq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

### src/werq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module werq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/werq_ctrl.sv
// Controller state machine sequencing each request through the datapath.
`default_nettype none

module werq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire werq_pkg::werq_sts_t sts,
  output werq_pkg::werq_cmd_t      cmd
);
  import werq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_SELECT  = 3'd3;
  localparam logic [2:0] S_FETCH   = 3'd4;
  localparam logic [2:0] S_CAPTURE = 3'd5;
  localparam logic [2:0] S_SHIFT   = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.pop_go) begin
          state_next = sts.elevator ? S_SCAN : S_FETCH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd.capture = 1'b1;
        state_next  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          cmd.pop_end = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        // Wait here only while the previous result is still unread.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### src/werq_dp.sv
// Datapath: queue storage, fill count, head position, window scan and compaction.
`default_nettype none

module werq_dp #(
  parameter int QUEUE_DEPTH = werq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = werq_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire werq_pkg::werq_cmd_t           cmd,
  output werq_pkg::werq_sts_t                sts,
  input  wire logic [werq_pkg::KIND_W-1:0]   req_kind,
  input  wire logic [werq_pkg::TAG_W-1:0]    req_tag,
  input  wire logic                          req_known,
  input  wire logic [werq_pkg::OFFSET_W-1:0] req_offset,
  werq_out_if.source                         rsp,
  werq_cfg_if.sink                           cfg
);
  import werq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int KEEP_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int ENT_W  = 1 + OFFSET_W + KEEP_W;
  localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  // Configuration registers.
  logic             elevator_enable;
  logic [CFG_W-1:0] scan_window;
  logic [CFG_W-1:0] queue_limit;

  // Queue state.
  logic [OCC_W-1:0]    occupancy;
  logic [OFFSET_W-1:0] head_offset;
  logic                moving_up;

  // Latched request.
  logic [KIND_W-1:0]   item_kind;
  logic [KEEP_W-1:0]   item_tag;
  logic                item_known;
  logic [OFFSET_W-1:0] item_offset;

  // Scan state.
  logic [OCC_W-1:0]    scan_addr;
  logic [IDX_W-1:0]    scan_idx;
  logic                scan_pend;
  logic                fit_found;
  logic [IDX_W-1:0]    fit_idx;
  logic [OFFSET_W-1:0] fit_pos;
  logic                ext_found;
  logic [IDX_W-1:0]    ext_idx;
  logic [OFFSET_W-1:0] ext_pos;

  // Removal state.
  logic [IDX_W-1:0] sel;
  logic [OCC_W-1:0] rd_ptr;
  logic [IDX_W-1:0] wr_ptr;
  logic             shift_pend;

  // Result being built.
  logic                res_ok;
  logic [KEEP_W-1:0]   res_tag;
  logic                res_known;
  logic [OFFSET_W-1:0] res_off;
  logic [COUNT_W-1:0]  res_drop;

  // Output register.
  logic                out_valid;
  logic                out_ok;
  logic [KEEP_W-1:0]   out_tag;
  logic                out_known;
  logic [OFFSET_W-1:0] out_off;
  logic [COUNT_W-1:0]  out_fill;
  logic                out_up;
  logic [COUNT_W-1:0]  out_drop;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic                ent_known;
  logic [OFFSET_W-1:0] ent_off;
  logic [KEEP_W-1:0]   ent_tag;

  logic push_ok;
  logic is_push;
  logic is_flush;
  logic scan_more;
  logic shift_more;
  logic fit_hit;
  logic fit_better;
  logic ext_better;

  assign ent_known = ram_rdata[ENT_W-1];
  assign ent_off   = ram_rdata[KEEP_W +: OFFSET_W];
  assign ent_tag   = ram_rdata[KEEP_W-1:0];

  assign is_push  = (item_kind == KIND_PUSH);
  assign is_flush = (item_kind == KIND_FLUSH);
  assign push_ok  = (CMP_W'(occupancy) < CMP_W'(queue_limit)) &&
                    (occupancy < OCC_W'(QUEUE_DEPTH));

  // The window covers the occupied entries up to the scan window.
  assign scan_more  = (CMP_W'(scan_addr) < CMP_W'(occupancy)) &&
                      (CMP_W'(scan_addr) < CMP_W'(scan_window));
  assign shift_more = (rd_ptr < occupancy);

  assign fit_hit    = moving_up ? (ent_off >= head_offset) : (ent_off <= head_offset);
  assign fit_better = !fit_found || (moving_up ? (ent_off < fit_pos) : (ent_off > fit_pos));
  assign ext_better = !ext_found || (moving_up ? (ent_off > ext_pos) : (ent_off < ext_pos));

  assign sts.pop_go     = (item_kind == KIND_POP) && (occupancy != '0);
  assign sts.elevator   = elevator_enable;
  assign sts.scan_done  = !scan_more && !scan_pend;
  assign sts.shift_done = !shift_more && !shift_pend;
  assign sts.out_free   = !out_valid || rsp.ready;

  assign ram_we = (cmd.exec && is_push && push_ok) || (cmd.shift && shift_pend);

  always_comb begin
    if (cmd.shift) begin
      ram_waddr = wr_ptr;
      ram_wdata = ram_rdata;
    end else begin
      ram_waddr = occupancy[IDX_W-1:0];
      ram_wdata = {item_known, item_offset, item_tag};
    end
  end

  always_comb begin
    priority if (cmd.fetch) begin
      ram_raddr = sel;
    end else if (cmd.shift) begin
      ram_raddr = rd_ptr[IDX_W-1:0];
    end else begin
      ram_raddr = scan_addr[IDX_W-1:0];
    end
  end

  werq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elevator_enable <= 1'b0;
      scan_window     <= CFG_W'(16);
      queue_limit     <= CFG_W'(16);
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_ELEVATOR: elevator_enable <= cfg.wdata[0];
        REG_WINDOW:   scan_window     <= cfg.wdata;
        REG_LIMIT:    queue_limit     <= cfg.wdata;
        default:      ;
      endcase
    end
  end

  // Latch the accepted request; an offset without a position is kept as zero.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind   <= req_kind;
      item_tag    <= req_tag[KEEP_W-1:0];
      item_known  <= req_known;
      item_offset <= req_known ? req_offset : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      head_offset <= '0;
      moving_up   <= 1'b1;
      scan_pend   <= 1'b0;
      fit_found   <= 1'b0;
      ext_found   <= 1'b0;
      shift_pend  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        scan_addr <= '0;
        scan_pend <= 1'b0;
        fit_found <= 1'b0;
        ext_found <= 1'b0;
        sel       <= '0;
        res_ok    <= (is_push && push_ok) || is_flush;
        res_tag   <= '0;
        res_known <= 1'b0;
        res_off   <= '0;
        res_drop  <= is_flush ? COUNT_W'(occupancy) : '0;
        if (is_push && push_ok) begin
          occupancy <= occupancy + OCC_W'(1);
        end else if (is_flush) begin
          occupancy <= '0;
        end
      end

      if (cmd.scan) begin
        // Reads run ahead of the comparison: each returned entry is compared in the cycle after its read.
        scan_pend <= scan_more;
        if (scan_more) begin
          scan_addr <= scan_addr + OCC_W'(1);
          scan_idx  <= scan_addr[IDX_W-1:0];
        end
        if (scan_pend && ent_known) begin
          if (fit_hit && fit_better) begin
            fit_found <= 1'b1;
            fit_idx   <= scan_idx;
            fit_pos   <= ent_off;
          end
          if (ext_better) begin
            ext_found <= 1'b1;
            ext_idx   <= scan_idx;
            ext_pos   <= ent_off;
          end
        end
      end

      if (cmd.select) begin
        if (fit_found) begin
          sel         <= fit_idx;
          head_offset <= fit_pos;
        end else if (ext_found) begin
          sel         <= ext_idx;
          head_offset <= ext_pos;
          moving_up   <= !moving_up;
        end else begin
          // Nothing positioned in the window: take the front, still turn around.
          sel       <= '0;
          moving_up <= !moving_up;
        end
      end

      if (cmd.fetch) begin
        rd_ptr     <= OCC_W'(sel) + OCC_W'(1);
        wr_ptr     <= sel;
        shift_pend <= 1'b0;
      end

      if (cmd.capture) begin
        res_ok    <= 1'b1;
        res_tag   <= ent_tag;
        res_known <= ent_known;
        res_off   <= ent_off;
      end

      if (cmd.shift) begin
        shift_pend <= shift_more;
        if (shift_more) begin
          rd_ptr <= rd_ptr + OCC_W'(1);
        end
        if (shift_pend) begin
          wr_ptr <= wr_ptr + IDX_W'(1);
        end
      end

      if (cmd.pop_end) begin
        occupancy <= occupancy - OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok    <= res_ok;
      out_tag   <= res_tag;
      out_known <= res_known;
      out_off   <= res_off;
      out_fill  <= COUNT_W'(occupancy);
      out_up    <= moving_up;
      out_drop  <= res_drop;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.done_ok            = out_ok;
  assign rsp.out_tag            = TAG_W'(out_tag);
  assign rsp.out_position_known = out_known;
  assign rsp.out_offset         = out_off;
  assign rsp.fill_level         = out_fill;
  assign rsp.heading_up         = out_up;
  assign rsp.dropped_count      = out_drop;

endmodule

`default_nettype wire

### src/windowed_elevator_request_queue_top.sv
// Top level of the windowed elevator request queue.
// Requests enter one at a time: a push appends a tagged entry, a pop removes one
// entry (the front one, or in elevator mode the best one among the front
// scan_window entries for the current head position and sweep direction), and
// a flush empties the queue; each request returns exactly one result. Entries
// live in a single RAM with one read and one write port, and that read port
// sets the pace: a push, a flush, a pop of an empty queue or an unknown kind
// is decoded and returns its result; a first-in first-out pop reads the front
// entry and then moves each entry behind it up a slot through that port; an
// elevator pop first reads the front entries, the smaller of fill and window,
// to choose one. A new request is accepted while the previous result still
// waits in the output register; the block holds only when a second result is
// ready before the first was taken. Configuration writes are always taken and
// are meant for moments when no request is in progress.
`default_nettype none

module windowed_elevator_request_queue_top #(
  parameter int QUEUE_DEPTH = werq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = werq_pkg::TAG_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  werq_in_if.sink    req,
  werq_out_if.source rsp,
  werq_cfg_if.sink   cfg
);
  import werq_pkg::*;

  werq_cmd_t cmd;
  werq_sts_t sts;

  werq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  werq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_kind   (req.kind),
    .req_tag    (req.request_tag),
    .req_known  (req.position_known),
    .req_offset (req.disk_offset),
    .rsp        (rsp),
    .cfg        (cfg)
  );

endmodule

`default_nettype wire

### bench/werq_scoreboard.sv
// Scoreboard for the request queue: tracks config writes, predicts each result and compares.
`timescale 1ns / 1ps

module werq_scoreboard (
  input  logic clk,
  input  logic rst,
  werq_in_if   req,
  werq_out_if  rsp,
  werq_cfg_if  cfg,
  output int   mismatches,
  output int   outstanding
);
  import werq_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int PEND_DEPTH = 8;

  typedef struct packed {
    logic                done_ok;
    logic [TAG_W-1:0]    tag;
    logic                pos_known;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  fill;
    logic                up;
    logic [COUNT_W-1:0]  dropped;
  } queue_result_t;

  // Mirror of the queue contents and scheduler state.
  logic [TAG_W-1:0]    slot_tag    [DEPTH];
  logic [OFFSET_W-1:0] slot_offset [DEPTH];
  logic                slot_has_pos[DEPTH];
  int                  queued;
  logic [OFFSET_W-1:0] head_pos;
  logic                sweep_up;

  logic                elevator_on;
  logic [CFG_W-1:0]    window_len;
  logic [CFG_W-1:0]    fill_cap;

  // Predicted results waiting for the block, oldest at pend_rd.
  queue_result_t awaited_results[PEND_DEPTH];
  int            pend_rd;
  int            pend_wr;
  int            pend_count;

  function automatic queue_result_t serve_request(logic [KIND_W-1:0] kind,
                                                  logic [TAG_W-1:0] tag,
                                                  logic known,
                                                  logic [OFFSET_W-1:0] offset);
    queue_result_t r;
    int cap;
    int span;
    int sel;
    int i;
    bit found;
    bit was_up;
    logic [OFFSET_W-1:0] best;
    r = '0;
    cap = (int'(fill_cap) > DEPTH) ? DEPTH : int'(fill_cap);
    case (kind)
      KIND_PUSH: begin
        if (queued < cap) begin
          slot_tag[queued] = tag;
          slot_has_pos[queued] = known;
          slot_offset[queued] = known ? offset : '0;
          queued++;
          r.done_ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (queued > 0) begin
          sel = 0;
          if (elevator_on) begin
            span = (queued < int'(window_len)) ? queued : int'(window_len);
            found = 0;
            best = '0;
            for (i = 0; i < span; i++) begin
              if (slot_has_pos[i] &&
                  (sweep_up ? (slot_offset[i] >= head_pos && (!found || slot_offset[i] < best))
                            : (slot_offset[i] <= head_pos && (!found || slot_offset[i] > best))))
              begin
                found = 1;
                sel = i;
                best = slot_offset[i];
              end
            end
            // Nothing ahead in the sweep: turn around and take the farthest entry.
            if (!found) begin
              was_up = sweep_up;
              sweep_up = !sweep_up;
              for (i = 0; i < span; i++) begin
                if (slot_has_pos[i] &&
                    (!found || (was_up ? slot_offset[i] > best : slot_offset[i] < best))) begin
                  found = 1;
                  sel = i;
                  best = slot_offset[i];
                end
              end
            end
            if (found) head_pos = best;
          end
          r.tag = slot_tag[sel];
          r.pos_known = slot_has_pos[sel];
          r.offset = slot_has_pos[sel] ? slot_offset[sel] : '0;
          for (i = sel; i + 1 < queued; i++) begin
            slot_tag[i] = slot_tag[i + 1];
            slot_offset[i] = slot_offset[i + 1];
            slot_has_pos[i] = slot_has_pos[i + 1];
          end
          queued--;
          r.done_ok = 1'b1;
        end
      end
      KIND_FLUSH: begin
        r.dropped = COUNT_W'(queued);
        queued = 0;
        r.done_ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.fill = COUNT_W'(queued);
    r.up = sweep_up;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    queue_result_t want;
    if (rst) begin
      queued = 0;
      head_pos = '0;
      sweep_up = 1'b1;
      elevator_on = 1'b0;
      window_len = CFG_W'(16);
      fill_cap = CFG_W'(16);
      pend_rd = 0;
      pend_wr = 0;
      pend_count = 0;
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_ELEVATOR: elevator_on = cfg.wdata[0];
          REG_WINDOW:   window_len = cfg.wdata;
          REG_LIMIT:    fill_cap = cfg.wdata;
          default: begin
          end
        endcase
      end
      // Results are checked before this edge's request is predicted, since a
      // request can never produce its result in the cycle it is accepted.
      if (rsp.valid && rsp.ready) begin
        if (pend_count == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results[pend_rd];
          pend_rd = (pend_rd + 1) % PEND_DEPTH;
          pend_count--;
          compare_field("done_ok", 64'(want.done_ok), 64'(rsp.done_ok));
          compare_field("out_tag", 64'(want.tag), 64'(rsp.out_tag));
          compare_field("out_position_known", 64'(want.pos_known),
                        64'(rsp.out_position_known));
          compare_field("out_offset", want.offset, rsp.out_offset);
          compare_field("fill_level", 64'(want.fill), 64'(rsp.fill_level));
          compare_field("heading_up", 64'(want.up), 64'(rsp.heading_up));
          compare_field("dropped_count", 64'(want.dropped), 64'(rsp.dropped_count));
        end
      end
      if (req.valid && req.ready) begin
        if (pend_count == PEND_DEPTH) begin
          $error("more requests taken than the block can hold results for");
          mismatches++;
        end else begin
          awaited_results[pend_wr] = serve_request(req.kind, req.request_tag,
                                                   req.position_known, req.disk_offset);
          pend_wr = (pend_wr + 1) % PEND_DEPTH;
          pend_count++;
        end
      end
    end
    outstanding = pend_count;
  end

endmodule

### bench/tb_windowed_elevator_request_queue_top.sv
// Testbench top for the request queue: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps

module tb_windowed_elevator_request_queue_top;
  import werq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  bit   calm;
  bit   long_hold;

  werq_in_if  req();
  werq_out_if rsp();
  werq_cfg_if cfg();

  windowed_elevator_request_queue_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  werq_scoreboard board (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_windowed_elevator_request_queue_top: FAIL");
    $finish;
  end

  // Result side: a random stall before each result, or one long hold-off when asked.
  initial begin : result_sink
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 0;
      end
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        rsp.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready = 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
      @(negedge clk);
    end
  end

  task automatic send_request(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                              logic known, logic [OFFSET_W-1:0] offset);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.kind = kind;
    req.request_tag = tag;
    req.position_known = known;
    req.disk_offset = offset;
    req.valid = 1'b1;
    do @(posedge clk); while (!(req.valid && req.ready));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg.reg_index = idx;
    cfg.wdata = value;
    cfg.valid = 1'b1;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // One setting of the registers followed by a burst of random requests that
  // alternates between filling and emptying the queue.
  task automatic run_phase(bit elev, logic [CFG_W-1:0] window, logic [CFG_W-1:0] limit,
                           int items, bit quiet, bit hold_sink);
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] offset;
    logic [CFG_W-2:0]    pad;
    int n;
    int roll;
    int burst;
    bit filling;
    pad = (CFG_W-1)'($urandom);
    write_reg(REG_ELEVATOR, {pad, elev});
    write_reg(REG_WINDOW, window);
    write_reg(REG_LIMIT, limit);
    calm = quiet;
    long_hold = hold_sink;
    filling = 1;
    burst = $urandom_range(8, 40);
    for (n = 0; n < items; n++) begin
      if (burst == 0) begin
        filling = !filling;
        burst = $urandom_range(8, 40);
      end
      burst--;
      roll = $urandom_range(0, 99);
      if (roll < 2) kind = KIND_FLUSH;
      else if (roll < 3) kind = KIND_UNUSED;
      else if (roll < (filling ? 75 : 30)) kind = KIND_PUSH;
      else kind = KIND_POP;
      // Mostly small positions so that ties and turnarounds are common.
      case ($urandom_range(0, 9))
        0: offset = '0;
        1: offset = '1;
        2, 3: offset = {$urandom, $urandom};
        default: offset = OFFSET_W'($urandom_range(0, 63));
      endcase
      send_request(kind, TAG_W'($urandom), $urandom_range(0, 4) != 0, offset);
    end
    drain();
  endtask

  initial begin : stimulus
    int p;
    rst = 1'b1;
    calm = 0;
    long_hold = 0;
    req.valid = 1'b0;
    req.kind = KIND_PUSH;
    req.request_tag = '0;
    req.position_known = 1'b0;
    req.disk_offset = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_ELEVATOR;
    cfg.wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Plain first-in first-out after reset: empty pop, field extremes, flush,
    // and a request of unknown kind.
    send_request(KIND_POP, '0, 1'b0, '0);
    send_request(KIND_PUSH, '0, 1'b0, '1);
    send_request(KIND_PUSH, '1, 1'b1, '1);
    send_request(KIND_PUSH, TAG_W'(16'h1234), 1'b1, '0);
    send_request(KIND_POP, '0, 1'b0, '0);
    send_request(KIND_FLUSH, '0, 1'b0, '0);
    send_request(KIND_UNUSED, '1, 1'b1, '1);
    drain();

    // Elevator order: nearest going up with a tie, an entry without a position
    // that forces a turn, then turns in both directions.
    run_phase(1'b1, CFG_W'(16), CFG_W'(16), 0, 1'b0, 1'b0);
    send_request(KIND_PUSH, TAG_W'(1), 1'b1, OFFSET_W'(100));
    send_request(KIND_PUSH, TAG_W'(2), 1'b1, OFFSET_W'(50));
    send_request(KIND_PUSH, TAG_W'(3), 1'b1, OFFSET_W'(200));
    send_request(KIND_PUSH, TAG_W'(4), 1'b0, OFFSET_W'(7));
    send_request(KIND_PUSH, TAG_W'(5), 1'b1, OFFSET_W'(100));
    repeat (5) send_request(KIND_POP, '0, 1'b0, '0);
    send_request(KIND_PUSH, TAG_W'(6), 1'b1, OFFSET_W'(300));
    send_request(KIND_PUSH, TAG_W'(7), 1'b1, OFFSET_W'(10));
    repeat (2) send_request(KIND_POP, '0, 1'b0, '0);
    send_request(KIND_PUSH, TAG_W'(8), 1'b1, OFFSET_W'(5));
    send_request(KIND_PUSH, TAG_W'(9), 1'b1, OFFSET_W'(7));
    repeat (2) send_request(KIND_POP, '0, 1'b0, '0);
    drain();

    run_phase(1'b1, CFG_W'(16), CFG_W'(16), 120, 1'b1, 1'b0);
    run_phase(1'b0, CFG_W'(16), CFG_W'(16), 100, 1'b0, 1'b1);
    run_phase(1'b1, CFG_W'(1), CFG_W'(16), 100, 1'b0, 1'b0);
    run_phase(1'b1, CFG_W'(0), CFG_W'(31), 80, 1'b0, 1'b0);
    run_phase(1'b1, CFG_W'(31), CFG_W'(1), 60, 1'b0, 1'b0);
    run_phase(1'b1, CFG_W'(4), CFG_W'(8), 100, 1'b0, 1'b0);
    run_phase(1'b0, CFG_W'(5), CFG_W'(0), 30, 1'b0, 1'b0);
    run_phase(1'b1, CFG_W'(16), CFG_W'(31), 120, 1'b0, 1'b0);
    for (p = 0; p < 4; p++)
      run_phase(1'($urandom_range(0, 1)), CFG_W'($urandom_range(0, 17)),
                CFG_W'($urandom_range(1, 17)), 100, $urandom_range(0, 3) == 0, 1'b0);

    // Let any stray result surface before the verdict.
    repeat (60) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_windowed_elevator_request_queue_top: PASS");
    else
      $display("tb_windowed_elevator_request_queue_top: FAIL");
    $finish;
  end

endmodule
